// ----- design/minmax_normalize_to_byte_top_defines.svh -----
`ifndef MINMAX_NORMALIZE_TO_BYTE_TOP_DEFINES_SVH
`define MINMAX_NORMALIZE_TO_BYTE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MMNB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MMNB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mmnb_pkg.sv -----
package mmnb_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flat_range;
  } out_item_t;

  localparam logic MODE_GATHER  = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  // quotient bits 8..0, bit 8 set means saturate
  localparam int DIV_STEPS = 9;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [7:0] PIXEL_MAX = 8'd255;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic gather;
    logic load;
    logic prep;
    logic step;
    logic emit;
  } dp_cmd_t;

endpackage

// ----- design/mmnb_ctrl.sv -----
module mmnb_ctrl
  import mmnb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_mode,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_CONVERT) begin
            cmd.load   = 1'b1;
            state_next = S_PREP;
          end else begin
            cmd.gather = 1'b1;
          end
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/mmnb_dp.sv -----
module mmnb_dp
  import mmnb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  logic signed [15:0] low_value, high_value;
  logic               gathering;
  logic signed [15:0] x_reg;
  logic [15:0]        range_q;
  logic               flat, neg;
  logic [25:0]        rem;
  logic [24:0]        dsh;
  logic [8:0]         quo;
  out_item_t          out_reg;

  logic signed [16:0] diff;
  logic [26:0]        num;
  logic               ge;

  // x - min scaled by 512, plus range
  assign diff    = {x_reg[15], x_reg} - {low_value[15], low_value};
  assign range_q = high_value - low_value;
  assign num     = {diff[16], diff, 9'd0} + {11'd0, range_q};

  assign ge = (rem >= {1'b0, dsh});

  always_ff @(posedge clk) begin
    if (rst) begin
      low_value  <= '0;
      high_value <= '0;
      gathering  <= 1'b0;
    end else if (cmd.gather) begin
      gathering <= 1'b1;
      if (!gathering) begin
        low_value  <= in_data.sample;
        high_value <= in_data.sample;
      end else begin
        if (in_data.sample < low_value)  low_value  <= in_data.sample;
        if (in_data.sample > high_value) high_value <= in_data.sample;
      end
    end else if (cmd.load) begin
      gathering <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg <= in_data.sample;
    end
    if (cmd.prep) begin
      rem  <= num[25:0];
      neg  <= num[26];
      flat <= (range_q == 16'd0);
      dsh  <= {range_q, 9'd0};
      quo  <= '0;
    end else if (cmd.step) begin
      if (ge) begin
        rem <= rem - {1'b0, dsh};
      end
      dsh <= dsh >> 1;
      quo <= {quo[7:0], ge};
    end
    if (cmd.emit) begin
      out_reg.flat_range <= flat;
      if (flat || neg) begin
        out_reg.pixel <= 8'd0;
      end else if (quo[8]) begin
        out_reg.pixel <= PIXEL_MAX;
      end else begin
        out_reg.pixel <= quo[7:0];
      end
    end
  end

  assign out_data = out_reg;

endmodule

// ----- design/minmax_normalize_to_byte_top.sv -----
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data  (mode, sample)
// out     | output    | out_valid / out_ready| out_data (pixel, flat_range)
//
// Gather item: taken while in_ready stays high.
// Convert item: in_ready drops through prep, 9 restoring divide steps and
// the output write, which can stall; no new item is taken meanwhile.
// Reset (rst, synchronous) clears min/max to 0 and ends any gather run.
// A finished pixel waits in the output register; gathers are still taken,
// and the next convert holds in its write cycle until out_ready.
`include "minmax_normalize_to_byte_top_defines.svh"

module minmax_normalize_to_byte_top
  import mmnb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t cmd;

  mmnb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mmnb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  `MMNB_ASSERT_NOW(a_no_overwrite, cmd.emit, (!out_valid || out_ready), "pending item overwritten")
  `MMNB_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_ready, "convert accepted while busy")
  `MMNB_ASSERT_NOW(a_flat_zero, (out_valid && out_data.flat_range), (out_data.pixel == 8'd0), "flat range with nonzero pixel")

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  import mmnb_pkg::*;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample;
    logic               fixed;
    logic [7:0]         pix;
    logic               flat;
  } stim_row_t;

  localparam int N_DIRECTED = 22;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 5000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  out_item_t expected_pixels[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_tok = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  logic signed [15:0] run_min = '0;
  logic signed [15:0] run_max = '0;
  bit                 run_open = 1'b0;

  // mode, sample, fixed expectation, pixel, flat_range
  stim_row_t dir_tab [0:N_DIRECTED-1] = '{
    '{MODE_CONVERT, 16'sh0000, 1'b1, 8'd0,   1'b1},  // before any gather
    '{MODE_GATHER,  16'sh8000, 1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  16'sh7FFF, 1'b0, 8'd0,   1'b0},
    '{MODE_CONVERT, 16'sh8000, 1'b1, 8'd0,   1'b0},
    '{MODE_CONVERT, 16'sh7FFF, 1'b1, 8'd255, 1'b0},
    '{MODE_CONVERT, 16'sh0000, 1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  16'sd100,  1'b0, 8'd0,   1'b0},  // new run after convert
    '{MODE_CONVERT, 16'sd100,  1'b1, 8'd0,   1'b1},
    '{MODE_GATHER,  16'sd0,    1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  16'sd1000, 1'b0, 8'd0,   1'b0},
    '{MODE_CONVERT, -16'sd5,   1'b1, 8'd0,   1'b0},  // below min
    '{MODE_CONVERT, 16'sd2000, 1'b1, 8'd255, 1'b0},  // above max
    '{MODE_CONVERT, 16'sd1000, 1'b1, 8'd255, 1'b0},  // equals max
    '{MODE_CONVERT, 16'sd500,  1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  -16'sd1,   1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  16'sd1,    1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  16'sd0,    1'b0, 8'd0,   1'b0},
    '{MODE_CONVERT, 16'sd0,    1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  16'sh8000, 1'b0, 8'd0,   1'b0},
    '{MODE_GATHER,  16'sh8001, 1'b0, 8'd0,   1'b0},
    '{MODE_CONVERT, 16'sh8001, 1'b1, 8'd255, 1'b0},
    '{MODE_CONVERT, 16'sh8000, 1'b1, 8'd0,   1'b0}
  };

  minmax_normalize_to_byte_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit predict_pixel(input in_item_t it, output out_item_t res);
    int x;
    int lo;
    int hi;
    int rng;
    int num;
    x = int'(it.sample);
    res = '0;
    if (it.mode == MODE_GATHER) begin
      if (!run_open) begin
        run_min = it.sample;
        run_max = it.sample;
        run_open = 1'b1;
      end else begin
        if (it.sample < run_min) run_min = it.sample;
        if (it.sample > run_max) run_max = it.sample;
      end
      return 1'b0;
    end
    run_open = 1'b0;
    lo = int'(run_min);
    hi = int'(run_max);
    rng = hi - lo;
    if (rng <= 0) begin
      res.pixel = '0;
      res.flat_range = 1'b1;
    end else begin
      num = 512 * (x - lo) + rng;
      if (num < 0) begin
        res.pixel = '0;
      end else begin
        num = num / (2 * rng);
        res.pixel = (num > 255) ? PIXEL_MAX : num[7:0];
      end
    end
    return 1'b1;
  endfunction

  task automatic send_item(input in_item_t it, input bit use_fixed, input out_item_t fixed_res);
    out_item_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (predict_pixel(it, res)) begin
      expected_pixels.push_back(use_fixed ? fixed_res : res);
    end
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int span;
    int base;
    int v;
    int k;
    int n;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) >= 8) begin
        // noise: any mode, any sample
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          it.mode = 1'($urandom_range(0, 1));
          it.sample = 16'($urandom);
          send_item(it, 1'b0, '0);
          sent++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: span = $urandom_range(0, 7);
          1: span = $urandom_range(0, 2000);
          default: span = $urandom_range(0, 65535);
        endcase
        base = $urandom_range(0, 65535);
        base = base - 32768;
        if (base > 32767 - span) base = 32767 - span;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          v = base + $urandom_range(0, span);
          it.mode = MODE_GATHER;
          it.sample = v[15:0];
          send_item(it, 1'b0, '0);
          sent++;
        end
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 9))
            6: v = base;
            7: v = base + span;
            8: v = $urandom;
            9: v = base - 1;
            default: v = base + $urandom_range(0, span);
          endcase
          it.mode = MODE_CONVERT;
          it.sample = v[15:0];
          send_item(it, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_tok) begin
      hold_seen <= hold_tok;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(negedge clk) begin : pixel_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel item: pixel=%0d flat_range=%0d",
               out_data.pixel, out_data.flat_range);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel !== want.pixel) begin
          $error("pixel: expected %0d, got %0d", want.pixel, out_data.pixel);
          errors++;
        end
        if (out_data.flat_range !== want.flat_range) begin
          $error("flat_range: expected %0d, got %0d", want.flat_range, out_data.flat_range);
          errors++;
        end
      end
    end
  end

  initial begin
    int i;
    int waited;
    in_item_t it;
    out_item_t fix;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 10;
    rx_stall_pct = 47;
    for (i = 0; i < N_DIRECTED; i++) begin
      it.mode = dir_tab[i].mode;
      it.sample = dir_tab[i].sample;
      fix.pixel = dir_tab[i].pix;
      fix.flat_range = dir_tab[i].flat;
      send_item(it, dir_tab[i].fixed, fix);
    end
    run_random(120);

    tx_idle_pct = 47;
    rx_stall_pct = 10;
    run_random(125);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_tok <= hold_tok + 1;  // long receiver hold-off while items keep coming
    run_random(135);

    in_valid <= 1'b0;
    waited = 0;
    while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixel items never arrived", expected_pixels.size());
      errors++;
    end
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/mmnb_pkg.sv
design/mmnb_ctrl.sv
design/mmnb_dp.sv
design/minmax_normalize_to_byte_top.sv
bench/tb_top.sv
